>>> src/hrs_pkg.sv
// Shared types, codes and helper functions for the hashed register store.
`timescale 1ns / 1ps
package hrs_pkg;
	localparam int unsigned NumBucketsDef = 64;
	localparam int unsigned MaxEntriesDef = 256;
	localparam int unsigned KeyW = 24;
	localparam int unsigned ValW = 64;

	typedef enum logic [2:0] {
		REQ_ADD = 3'd0,
		REQ_WR_STRICT = 3'd1,
		REQ_WR_OWNER = 3'd2,
		REQ_RD_OWNER = 3'd3,
		REQ_RD_STRICT = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_DENIED = 3'd2,
		ST_BAD_TYPE = 3'd3,
		ST_FULL = 3'd4
	} status_t;

	localparam logic [1:0] ACC_RO = 2'd1;
	localparam logic [1:0] ACC_WO = 2'd2;

	function automatic logic [63:0] type_mask(input logic [3:0] t);
		logic [63:0] m;
		unique case (t)
			4'd1, 4'd2: m = 64'h0000_0000_0000_00FF;
			4'd3, 4'd4: m = 64'h0000_0000_0000_FFFF;
			4'd5, 4'd6, 4'd7: m = 64'h0000_0000_FFFF_FFFF;
			4'd8: m = 64'hFFFF_FFFF_FFFF_FFFF;
			default: m = 64'h0;
		endcase
		return m;
	endfunction

	function automatic logic type_ok(input logic [3:0] t);
		return (t >= 4'd1) && (t <= 4'd8);
	endfunction
endpackage

>>> src/hrs_ram.sv
// Generic single-port-write, one-read-port RAM with registered read data.
`timescale 1ns / 1ps
module hrs_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/hrs_hash.sv
// Sequential bucket hash: accumulates d*31, then r*17, then s, giving d*31 + r*17 + s.
`timescale 1ns / 1ps
module hrs_hash (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [7:0] dev_addr,
	input logic [7:0] reg_num,
	input logic [7:0] sub_num,
	output logic done,
	output logic [13:0] sum
);
	logic [1:0] step_q;
	logic [13:0] acc_q;
	logic [13:0] addend;

	always_comb begin
		unique case (step_q)
			2'd1: addend = {1'b0, dev_addr, 5'd0} - {6'd0, dev_addr};
			2'd2: addend = {2'b0, reg_num, 4'd0} + {6'd0, reg_num};
			default: addend = {6'd0, sub_num};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
			acc_q <= '0;
		end else if (start) begin
			step_q <= 2'd1;
			acc_q <= '0;
		end else if (step_q != 2'd0) begin
			acc_q <= acc_q + addend;
			step_q <= (step_q == 2'd3) ? 2'd0 : step_q + 2'd1;
		end
	end

	assign done = (step_q == 2'd3);
	assign sum = acc_q + addend;
endmodule

>>> src/hashed_register_store_core.sv
// Top level of the hashed register store: sequencer, bucket heads and entry pool.
`timescale 1ns / 1ps
// Usage:
// The input channel (in_valid/in_stall) carries one request word: a request code,
// a device/register/subregister key, a type, an access mode and a 64-bit value.
// The output channel (out_valid/out_stall) returns one result word per request:
// status, read value, found type, used entry count and empty bucket count.
// A request occupies the block alone: it is hashed, its bucket head is read,
// each chain entry visited is read on the entry memory read port and checked,
// and the result is registered. An add, or a miss on an empty bucket, stops at
// the bucket head; a full pool, bad type or unknown request goes from the hash
// to the result. The next request is accepted only once the result is taken.
// in_stall is high while a request is in progress or a result is held.
// The result waits in its output register while out_stall is high.
// Reset clears the bucket valid bits and allocation count, sets the empty bucket
// count to NUM_BUCKETS; the entry memories are not cleared and need no sweep.
// The user writes own_address via cfg_we/cfg_wdata only while idle (not enforced).
module hashed_register_store_core
	import hrs_pkg::*;
#(
	parameter int unsigned NUM_BUCKETS = NumBucketsDef,
	parameter int unsigned MAX_ENTRIES = MaxEntriesDef
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [7:0] cfg_wdata,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] req_type,
	input logic [7:0] dev_addr,
	input logic [7:0] reg_num,
	input logic [7:0] sub_num,
	input logic [3:0] new_type,
	input logic [1:0] new_access,
	input logic [63:0] write_value,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] status,
	output logic [63:0] read_value,
	output logic [3:0] found_type,
	output logic [8:0] used_entries,
	output logic [6:0] empty_buckets
);
	localparam int unsigned BW = $clog2(NUM_BUCKETS > 1 ? NUM_BUCKETS : 2);
	localparam int unsigned EW = $clog2(MAX_ENTRIES > 1 ? MAX_ENTRIES : 2);
	localparam int unsigned LW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned KIW = 30;

	typedef enum logic [2:0] {
		S_IDLE, S_HASH, S_HREAD, S_HEAD, S_FETCH, S_CHECK, S_DONE
	} state_t;

	state_t state_q;
	logic [7:0] own_q;
	logic [2:0] req_q;
	logic [7:0] dev_q, reg_q, sub_q;
	logic [3:0] nt_q;
	logic [1:0] na_q;
	logic [63:0] wv_q;
	logic [BW-1:0] bkt_q;
	logic [LW-1:0] link_q;
	logic [CW-1:0] steps_q;
	logic [CW-1:0] alloc_q;
	logic [BW:0] empty_q;
	logic [NUM_BUCKETS-1:0] bvalid_q;

	logic hash_done;
	logic [13:0] hash_sum;

	logic head_we;
	logic [LW-1:0] head_wdata, head_rdata, head_link;
	logic [BW-1:0] head_waddr;

	logic ent_we;
	logic [EW-1:0] ent_waddr, ent_raddr;
	logic [KIW-1:0] ki_rdata;
	logic [LW-1:0] nx_rdata;
	logic val_we;
	logic [EW-1:0] val_waddr;
	logic [63:0] val_wdata, val_rdata;

	logic in_acc;
	logic is_add;
	logic [3:0] et;
	logic [1:0] ea;
	logic owner, deny, hit;

	assign in_stall = (state_q != S_IDLE) || out_valid;
	assign in_acc = in_valid && !in_stall;
	assign is_add = (req_q == REQ_ADD);

	hrs_hash u_hash (
		.clk(clk), .arst_n(arst_n), .start(in_acc),
		.dev_addr(dev_q), .reg_num(reg_q), .sub_num(sub_q),
		.done(hash_done), .sum(hash_sum)
	);

	hrs_ram #(.Width(LW), .Depth(NUM_BUCKETS)) u_head (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(bkt_q), .rdata(head_rdata)
	);
	assign head_link = bvalid_q[bkt_q] ? head_rdata : '0;

	hrs_ram #(.Width(KIW), .Depth(MAX_ENTRIES)) u_key (
		.clk(clk), .we(ent_we), .waddr(ent_waddr),
		.wdata({na_q, nt_q, dev_q, reg_q, sub_q}),
		.raddr(ent_raddr), .rdata(ki_rdata)
	);
	hrs_ram #(.Width(LW), .Depth(MAX_ENTRIES)) u_next (
		.clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(head_link),
		.raddr(ent_raddr), .rdata(nx_rdata)
	);
	hrs_ram #(.Width(64), .Depth(MAX_ENTRIES)) u_val (
		.clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
		.raddr(ent_raddr), .rdata(val_rdata)
	);

	assign ent_raddr = EW'(link_q - LW'(1));
	assign et = ki_rdata[27:24];
	assign ea = ki_rdata[29:28];
	assign hit = (ki_rdata[23:0] == {dev_q, reg_q, sub_q});
	assign owner = (dev_q == own_q);

	always_comb begin
		unique case (req_q)
			REQ_WR_STRICT: deny = (ea == ACC_RO);
			REQ_WR_OWNER: deny = !owner && (ea == ACC_RO);
			REQ_RD_OWNER: deny = !owner && (ea == ACC_WO);
			default: deny = (ea == ACC_WO);
		endcase
	end

	wire add_go = (state_q == S_HEAD) && is_add;
	assign ent_we = add_go;
	assign ent_waddr = EW'(alloc_q);
	assign head_we = add_go;
	assign head_waddr = bkt_q;
	assign head_wdata = LW'(alloc_q) + LW'(1);

	wire wr_go = (state_q == S_CHECK) && (link_q != '0) && hit && !deny && type_ok(et)
		&& (req_q == REQ_WR_STRICT || req_q == REQ_WR_OWNER);
	assign val_we = add_go || wr_go;
	assign val_waddr = add_go ? EW'(alloc_q) : ent_raddr;
	assign val_wdata = add_go ? (wv_q & type_mask(nt_q)) : (wv_q & type_mask(et));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			own_q <= '0;
			out_valid <= 1'b0;
			alloc_q <= '0;
			empty_q <= (BW + 1)'(NUM_BUCKETS);
			bvalid_q <= '0;
			status <= ST_OK;
			read_value <= '0;
			found_type <= '0;
			link_q <= '0;
			steps_q <= '0;
		end else begin
			if (cfg_we) begin
				own_q <= cfg_wdata;
			end
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						req_q <= req_type;
						dev_q <= dev_addr;
						reg_q <= reg_num;
						sub_q <= sub_num;
						nt_q <= new_type;
						na_q <= new_access;
						wv_q <= write_value;
						status <= ST_NOT_FOUND;
						read_value <= '0;
						found_type <= '0;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						bkt_q <= BW'(hash_sum % 14'(NUM_BUCKETS));
						state_q <= S_HREAD;
						if (req_q == REQ_ADD) begin
							if (alloc_q >= CW'(MAX_ENTRIES)) begin
								status <= ST_FULL;
								state_q <= S_DONE;
							end else if (!type_ok(nt_q)) begin
								status <= ST_BAD_TYPE;
								state_q <= S_DONE;
							end
						end else if (req_q > REQ_RD_STRICT) begin
							state_q <= S_DONE;
						end
					end
				end
				S_HREAD: begin
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					if (is_add) begin
						if (!bvalid_q[bkt_q] || head_rdata == '0) begin
							if (empty_q != '0) begin
								empty_q <= empty_q - 1'b1;
							end
						end
						bvalid_q[bkt_q] <= 1'b1;
						alloc_q <= alloc_q + 1'b1;
						status <= ST_OK;
						state_q <= S_DONE;
					end else begin
						link_q <= head_link;
						steps_q <= '0;
						state_q <= (head_link == '0) ? S_DONE : S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (hit) begin
						found_type <= et;
						if (deny) begin
							status <= ST_DENIED;
						end else if (!type_ok(et)) begin
							status <= ST_BAD_TYPE;
						end else begin
							status <= ST_OK;
							if (req_q == REQ_RD_OWNER || req_q == REQ_RD_STRICT) begin
								read_value <= val_rdata & type_mask(et);
							end
						end
						state_q <= S_DONE;
					end else if (nx_rdata == '0 || nx_rdata > LW'(MAX_ENTRIES)
							|| steps_q + 1'b1 >= CW'(MAX_ENTRIES)) begin
						state_q <= S_DONE;
					end else begin
						link_q <= nx_rdata;
						steps_q <= steps_q + 1'b1;
						state_q <= S_FETCH;
					end
				end
				S_DONE: begin
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign used_entries = 9'(alloc_q);
	assign empty_buckets = 7'(empty_q);

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("request accepted while busy");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> out_valid)
		else $error("result not presented");
	a_alloc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_q <= CW'(MAX_ENTRIES))
		else $error("pool overflow");
	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		(alloc_q != $past(alloc_q)) |-> ($past(state_q) == S_HEAD))
		else $error("allocation outside add");
endmodule

>>> tb/tb_hashed_register_store_core.sv
// Self-checking testbench for the hashed register store: keyed adds, typed reads and writes.
`timescale 1ns / 1ps
module tb_hashed_register_store_core;
	import hrs_pkg::*;

	localparam int NBKT = 64;
	localparam int NENT = 256;

	typedef struct {
		logic [2:0] st;
		logic [63:0] rv;
		logic [3:0] ft;
		logic [8:0] used;
		logic [6:0] empty;
	} reg_result_t;

	class store_scoreboard;
		logic [8:0] head [NBKT];
		logic [29:0] info [NENT];
		logic [63:0] val [NENT];
		logic [8:0] nxt [NENT];
		int unsigned used_cnt;
		int unsigned empty_cnt;
		logic [7:0] own;
		reg_result_t pending [$];
		int errors;
		int checked;
		int n_ok, n_denied, n_full, n_badtype, n_missing;

		function void clear();
			foreach (head[b]) head[b] = '0;
			used_cnt = 0;
			empty_cnt = NBKT;
			own = '0;
			errors = 0;
			checked = 0;
		endfunction

		function logic [63:0] width_mask(logic [3:0] t);
			case (t)
				4'd1, 4'd2: return 64'hFF;
				4'd3, 4'd4: return 64'hFFFF;
				4'd5, 4'd6, 4'd7: return 64'hFFFF_FFFF;
				4'd8: return '1;
				default: return '0;
			endcase
		endfunction

		function int hash_bucket(logic [7:0] d, logic [7:0] r, logic [7:0] s);
			return (int'(d) * 31 + int'(r) * 17 + int'(s)) % NBKT;
		endfunction

		function void note_request(logic [2:0] rq, logic [7:0] d, logic [7:0] r,
				logic [7:0] s, logic [3:0] nt, logic [1:0] na, logic [63:0] wv);
			reg_result_t e;
			int b, i, steps;
			logic [8:0] link;
			logic [3:0] et;
			logic [1:0] ea;
			logic deny, owner;
			e.st = ST_NOT_FOUND;
			e.rv = '0;
			e.ft = '0;
			if (rq == REQ_ADD) begin
				if (used_cnt >= NENT) begin
					e.st = ST_FULL;
				end else if (nt < 1 || nt > 8) begin
					e.st = ST_BAD_TYPE;
				end else begin
					b = hash_bucket(d, r, s);
					i = used_cnt;
					info[i] = {na, nt, d, r, s};
					val[i] = wv & width_mask(nt);
					nxt[i] = head[b];
					if (head[b] == 0 && empty_cnt > 0) empty_cnt--;
					head[b] = 9'(i + 1);
					used_cnt++;
					e.st = ST_OK;
				end
			end else if (rq <= REQ_RD_STRICT) begin
				link = head[hash_bucket(d, r, s)];
				steps = 0;
				while (link != 0 && steps < NENT && info[link - 1][23:0] != {d, r, s}) begin
					link = nxt[link - 1];
					steps++;
				end
				if (steps >= NENT) link = 0;
				if (link != 0) begin
					i = link - 1;
					et = info[i][27:24];
					ea = info[i][29:28];
					owner = (d == own);
					e.ft = et;
					case (rq)
						REQ_WR_STRICT: deny = (ea == ACC_RO);
						REQ_WR_OWNER: deny = !owner && ea == ACC_RO;
						REQ_RD_OWNER: deny = !owner && ea == ACC_WO;
						default: deny = (ea == ACC_WO);
					endcase
					if (deny) begin
						e.st = ST_DENIED;
					end else if (et < 1 || et > 8) begin
						e.st = ST_BAD_TYPE;
					end else if (rq <= REQ_WR_OWNER) begin
						val[i] = wv & width_mask(et);
						e.st = ST_OK;
					end else begin
						e.rv = val[i] & width_mask(et);
						e.st = ST_OK;
					end
				end
			end
			e.used = 9'(used_cnt);
			e.empty = 7'(empty_cnt);
			case (e.st)
				ST_OK: n_ok++;
				ST_DENIED: n_denied++;
				ST_FULL: n_full++;
				ST_BAD_TYPE: n_badtype++;
				default: n_missing++;
			endcase
			pending.push_back(e);
		endfunction

		function void check_result(reg_result_t a);
			reg_result_t e;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word st=%0d", $time, a.st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.st !== e.st) begin
				$display("%0t: status exp %0d got %0d", $time, e.st, a.st);
				errors++;
			end
			if (a.rv !== e.rv) begin
				$display("%0t: read_value exp %h got %h", $time, e.rv, a.rv);
				errors++;
			end
			if (a.ft !== e.ft) begin
				$display("%0t: found_type exp %0d got %0d", $time, e.ft, a.ft);
				errors++;
			end
			if (a.used !== e.used) begin
				$display("%0t: used_entries exp %0d got %0d", $time, e.used, a.used);
				errors++;
			end
			if (a.empty !== e.empty) begin
				$display("%0t: empty_buckets exp %0d got %0d", $time, e.empty, a.empty);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] req_type = '0;
	logic [7:0] dev_addr = '0;
	logic [7:0] reg_num = '0;
	logic [7:0] sub_num = '0;
	logic [3:0] new_type = '0;
	logic [1:0] new_access = '0;
	logic [63:0] write_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [63:0] read_value;
	logic [3:0] found_type;
	logic [8:0] used_entries;
	logic [6:0] empty_buckets;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	int sent = 0;

	store_scoreboard sb;

	hashed_register_store_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
		.dev_addr(dev_addr), .reg_num(reg_num), .sub_num(sub_num),
		.new_type(new_type), .new_access(new_access), .write_value(write_value),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.read_value(read_value), .found_type(found_type), .used_entries(used_entries),
		.empty_buckets(empty_buckets)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		reg_result_t a;
		if (arst_n && out_valid && !out_stall) begin
			a.st = status;
			a.rv = read_value;
			a.ft = found_type;
			a.used = used_entries;
			a.empty = empty_buckets;
			sb.check_result(a);
		end
	end

	task automatic send_word(logic [2:0] rq, logic [7:0] d, logic [7:0] r, logic [7:0] s,
			logic [3:0] nt, logic [1:0] na, logic [63:0] wv);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		dev_addr <= d;
		reg_num <= r;
		sub_num <= s;
		new_type <= nt;
		new_access <= na;
		write_value <= wv;
		do @(posedge clk); while (in_stall);
		sb.note_request(rq, d, r, s, nt, na, wv);
		sent++;
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_own(logic [7:0] a);
		wait_drain();
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.own = a;
	endtask

	function automatic logic [63:0] rand64();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// keys drawn from a small pool so lookups hit and chains grow
	logic [7:0] kd [16];
	logic [7:0] kr [16];
	logic [7:0] ks [16];

	task automatic random_word(bit pooled);
		int k;
		logic [2:0] rq;
		logic [3:0] nt;
		k = $urandom_range(15);
		rq = ($urandom_range(99) < 4) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
		if (rq == REQ_ADD && sb.used_cnt < NENT && $urandom_range(3) != 0 && !pooled)
			rq = 3'($urandom_range(1, 4));
		nt = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
		if (pooled && $urandom_range(7) != 0)
			send_word(rq, kd[k], kr[k], ks[k], nt, 2'($urandom), rand64());
		else if ($urandom_range(1))
			send_word(rq, sb.own, kr[k], ks[k], nt, 2'($urandom), rand64());
		else
			send_word(rq, 8'($urandom), 8'($urandom), 8'($urandom), nt, 2'($urandom),
				rand64());
	endtask

	task automatic random_phase(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (n) random_word(sb.used_cnt < NENT);
	endtask

	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		sb = new();
		sb.clear();
		foreach (kd[i]) begin
			kd[i] = 8'($urandom);
			kr[i] = 8'($urandom);
			ks[i] = 8'($urandom);
		end
		kd[0] = 8'h00; kr[0] = 8'h00; ks[0] = 8'h00;
		kd[1] = 8'hFF; kr[1] = 8'hFF; ks[1] = 8'hFF;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_own(8'h00);
		send_word(REQ_RD_STRICT, 8'h00, 8'h00, 8'h00, 4'd1, 2'd0, '0);
		send_word(REQ_ADD, 8'h00, 8'h00, 8'h00, 4'd0, 2'd0, '1);
		send_word(REQ_ADD, 8'h00, 8'h00, 8'h00, 4'd15, 2'd0, '1);
		send_word(REQ_ADD, 8'h00, 8'h00, 8'h00, 4'd1, 2'd0, '1);
		send_word(REQ_ADD, 8'hFF, 8'hFF, 8'hFF, 4'd8, 2'd1, '1);
		send_word(REQ_ADD, 8'h01, 8'h02, 8'h03, 4'd2, 2'd2, 64'h1234);
		send_word(REQ_ADD, 8'h02, 8'h00, 8'h00, 4'd7, 2'd3, '1);
		send_word(REQ_ADD, 8'h00, 8'h00, 8'h00, 4'd3, 2'd1, '1);
		send_word(REQ_RD_STRICT, 8'h00, 8'h00, 8'h00, 4'd0, 2'd0, '0);
		send_word(REQ_WR_STRICT, 8'h00, 8'h00, 8'h00, 4'd0, 2'd0, '0);
		send_word(REQ_WR_OWNER, 8'h00, 8'h00, 8'h00, 4'd0, 2'd0, 64'hABCD_EF01);
		send_word(REQ_RD_OWNER, 8'h00, 8'h00, 8'h00, 4'd0, 2'd0, '0);
		send_word(REQ_WR_OWNER, 8'hFF, 8'hFF, 8'hFF, 4'd0, 2'd0, '0);
		send_word(REQ_RD_STRICT, 8'h01, 8'h02, 8'h03, 4'd0, 2'd0, '0);
		send_word(REQ_RD_OWNER, 8'h01, 8'h02, 8'h03, 4'd0, 2'd0, '0);
		send_word(REQ_WR_STRICT, 8'h02, 8'h00, 8'h00, 4'd0, 2'd0, 64'h5555_AAAA_5555);
		send_word(REQ_RD_STRICT, 8'h02, 8'h00, 8'h00, 4'd0, 2'd0, '0);
		send_word(3'd5, 8'h00, 8'h00, 8'h00, 4'd1, 2'd0, '0);
		send_word(3'd7, 8'hFF, 8'hFF, 8'hFF, 4'd8, 2'd3, '1);
		set_own(8'hFF);
		send_word(REQ_WR_OWNER, 8'hFF, 8'hFF, 8'hFF, 4'd0, 2'd0, 64'h0F0F);
		send_word(REQ_RD_STRICT, 8'hFF, 8'hFF, 8'hFF, 4'd0, 2'd0, '0);
		send_word(REQ_RD_OWNER, 8'h01, 8'h02, 8'h03, 4'd0, 2'd0, '0);

		random_phase(150, 0, 0);
		set_own(8'($urandom));
		random_phase(120, 82, 0);
		hold_cycles = 300;
		random_phase(30, 0, 0);
		random_phase(120, 0, 82);
		set_own(8'h01);
		random_phase(120, 33, 33);
		set_own(8'($urandom));
		repeat (300) random_word(0);
		while (sb.used_cnt < NENT) send_word(REQ_ADD, 8'($urandom), 8'($urandom),
			8'($urandom), 4'($urandom_range(1, 8)), 2'($urandom), rand64());
		send_word(REQ_ADD, 8'h00, 8'h00, 8'h00, 4'd0, 2'd0, '0);
		random_phase(150, 33, 33);
		set_own(8'h00);
		random_phase(250, 0, 0);
		wait_drain();

		$display("Covered %0d requests, %0d results checked, pool filled to %0d entries.",
			sent, sb.checked, sb.used_cnt);
		$display("Status mix: ok %0d, missing %0d, denied %0d, bad type %0d, full %0d.",
			sb.n_ok, sb.n_missing, sb.n_denied, sb.n_badtype, sb.n_full);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
